// ----- rtl/hfe_pkg.sv -----
`default_nettype none
package hfe_pkg;

  localparam int NUM_BINS_DEF = 256;
  localparam int QUEUE_DEPTH  = 2;

  localparam int SAMPLE_W = 32;
  localparam int SEL_W    = 8;
  localparam int BINS_W   = 9;
  localparam int COUNT_W  = 32;
  localparam int ROOT_W   = 24;
  localparam int CFG_IDX_W = 2;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS      = 2'd2;

  localparam logic [SAMPLE_W-1:0] RANGE_MIN_RST = 32'd0;
  localparam logic [SAMPLE_W-1:0] RANGE_MAX_RST = 32'd256;
  localparam logic [BINS_W-1:0]   BINS_RST      = 9'd256;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_RD,
    B_UPD,
    B_ROOT,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic             fill;
    logic             hit;
    logic [SEL_W-1:0] bin_index;
  } hfe_item_t;

endpackage
`default_nettype wire

// ----- rtl/hfe_queue.sv -----
`default_nettype none
module hfe_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hfe_front.sv -----
`default_nettype none
module hfe_front #(
  parameter int NUM_BINS = hfe_pkg::NUM_BINS_DEF,
  parameter int IDXW     = $clog2(NUM_BINS)
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  input  wire logic [hfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hfe_pkg::SAMPLE_W-1:0]     cfg_data,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [hfe_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                             in_tuser,
  input  wire logic                             clear_busy,
  output logic                                  push,
  output logic [IDXW+$bits(hfe_pkg::hfe_item_t)-1:0] push_data,
  input  wire logic                             full
);
  import hfe_pkg::*;

  localparam int NBW = $clog2(NUM_BINS + 1);
  localparam int PW  = SAMPLE_W + NBW;
  localparam int KW  = $clog2(IDXW + 1);

  front_state_t state_r, state_nxt;

  logic signed [SAMPLE_W-1:0] min_r, max_r;
  logic [BINS_W-1:0]          bins_r;

  logic [31:0]         bins32, nb32, sel32;
  logic [NBW-1:0]      nb;
  logic signed [SAMPLE_W-1:0] xs;
  logic [SEL_W-1:0]    sel;
  logic                in_range, accept, ge;

  logic [SAMPLE_W-1:0] off_r, span_r;
  logic [NBW-1:0]      nb_r;
  logic [PW-1:0]       rem_r, d_r;
  logic [IDXW-1:0]     q_r;
  logic [KW-1:0]       k_r;
  hfe_item_t           item_r;

  assign xs  = in_tdata[SAMPLE_W-1:0];
  assign sel = in_tdata[SAMPLE_W+SEL_W-1:SAMPLE_W];

  always_comb begin
    bins32 = 32'(bins_r);
    if (bins32 == 32'd0) begin
      nb32 = 32'd1;
    end else if (bins32 > 32'(NUM_BINS)) begin
      nb32 = 32'(NUM_BINS);
    end else begin
      nb32 = bins32;
    end
    nb       = nb32[NBW-1:0];
    sel32    = 32'(sel);
    in_range = (max_r > min_r) && (xs >= min_r) && (xs < max_r);
  end

  assign accept = in_tvalid && in_tready;
  assign ge     = (rem_r >= d_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = (!in_tuser && in_range) ? F_MUL : F_PUSH;
        end
      end
      F_MUL:  state_nxt = F_DIV;
      F_DIV: begin
        if (k_r == '0) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    push      = 1'b0;
    case (state_r)
      F_IDLE:  in_tready = !clear_busy;
      F_PUSH:  push = 1'b1;
      default: begin
        in_tready = 1'b0;
        push      = 1'b0;
      end
    endcase
  end

  assign push_data = {q_r, item_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      min_r   <= RANGE_MIN_RST;
      max_r   <= RANGE_MAX_RST;
      bins_r  <= BINS_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_RANGE_MIN: min_r  <= cfg_data;
          CFG_RANGE_MAX: max_r  <= cfg_data;
          CFG_BINS:      bins_r <= cfg_data[BINS_W-1:0];
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          off_r  <= xs - min_r;
          span_r <= max_r - min_r;
          nb_r   <= nb;
          if (in_tuser) begin
            item_r.fill      <= 1'b0;
            item_r.hit       <= (sel32 < nb32);
            item_r.bin_index <= sel;
            q_r              <= sel32[IDXW-1:0];
          end else begin
            item_r.fill      <= 1'b1;
            item_r.hit       <= in_range;
            item_r.bin_index <= '0;
            q_r              <= '0;
          end
        end
      end
      F_MUL: begin
        rem_r <= PW'(off_r * nb_r);
        d_r   <= PW'(span_r) << (IDXW - 1);
        k_r   <= KW'(IDXW - 1);
        q_r   <= '0;
      end
      F_DIV: begin
        if (ge) begin
          rem_r <= rem_r - d_r;
        end
        d_r <= d_r >> 1;
        q_r <= IDXW'({q_r, ge});
        k_r <= k_r - 1'b1;
        if (k_r == '0) begin
          item_r.bin_index <= 8'(32'({q_r, ge}));
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/hfe_back.sv -----
`default_nettype none
module hfe_back #(
  parameter int NUM_BINS = hfe_pkg::NUM_BINS_DEF,
  parameter int IDXW     = $clog2(NUM_BINS)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  output logic                                   clear_busy,
  output logic                                   pop,
  input  wire logic [IDXW+$bits(hfe_pkg::hfe_item_t)-1:0] pop_data,
  input  wire logic                              empty,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [hfe_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                   out_tuser
);
  import hfe_pkg::*;

  localparam int VW   = COUNT_W + 16;
  localparam int REMW = ROOT_W + 2;
  localparam int ITW  = $clog2(ROOT_W);

  back_state_t state_r, state_nxt;

  logic [COUNT_W-1:0] mem [NUM_BINS];
  logic [COUNT_W-1:0] rd_q;

  logic [IDXW-1:0]    clr_r;
  logic [IDXW-1:0]    idx_r;
  hfe_item_t          ent_r;
  hfe_item_t          ent_in;
  logic [COUNT_W-1:0] total_r, count_nxt;
  logic [VW-1:0]      v_r;
  logic [REMW-1:0]    rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [ITW-1:0]     it_r;
  logic [REMW+1:0]    rem_sh, trial;
  logic               sq_ge;

  logic               mem_we;
  logic [IDXW-1:0]    mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;
  logic               out_free, out_load;

  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic               out_user_r;

  assign ent_in   = pop_data[$bits(hfe_item_t)-1:0];
  assign out_free = !out_valid_r || out_tready;

  assign count_nxt = (ent_r.fill && rd_q != COUNT_MAX) ? rd_q + 1'b1 : rd_q;
  assign rem_sh    = {rem_r, v_r[VW-1:VW-2]};
  assign trial     = {2'b00, root_r, 2'b01};
  assign sq_ge     = (rem_sh >= trial);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLEAR: begin
        if (clr_r == IDXW'(NUM_BINS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty) begin
          state_nxt = ent_in.hit ? B_RD : B_DONE;
        end
      end
      B_RD:  state_nxt = B_UPD;
      B_UPD: state_nxt = B_ROOT;
      B_ROOT: begin
        if (it_r == ITW'(ROOT_W - 1)) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    clear_busy = 1'b0;
    pop        = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = count_nxt;
    out_load   = 1'b0;
    case (state_r)
      B_CLEAR: begin
        clear_busy = 1'b1;
        mem_we     = 1'b1;
        mem_waddr  = clr_r;
        mem_wdata  = '0;
      end
      B_IDLE:  pop = !empty;
      B_UPD:   mem_we = ent_r.fill && (rd_q != COUNT_MAX);
      B_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        ent_r   <= ent_in;
        idx_r   <= pop_data[IDXW+$bits(hfe_item_t)-1:$bits(hfe_item_t)];
        total_r <= '0;
        root_r  <= '0;
      end
      B_UPD: begin
        total_r <= count_nxt;
        v_r     <= {count_nxt, 16'h0000};
        rem_r   <= '0;
        root_r  <= '0;
        it_r    <= '0;
      end
      B_ROOT: begin
        rem_r  <= sq_ge ? REMW'(rem_sh - trial) : REMW'(rem_sh);
        root_r <= {root_r[ROOT_W-2:0], sq_ge};
        v_r    <= v_r << 2;
        it_r   <= it_r + 1'b1;
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r <= {root_r, total_r, ent_r.bin_index};
      out_user_r <= ent_r.hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

// ----- rtl/histogram_fill_with_error.sv -----
`default_nettype none
// Uniform-bin histogram with a square-root error estimate. A fill beat (in_tuser 0) bins the
// signed sample over [range_min, range_max) into bins_in_use equal bins and bumps that bin's
// count, saturating; a read beat (in_tuser 1) returns the count of bin_select. Every input beat
// gives one output beat with hit, bin, count and floor(sqrt(count) * 256). The front end
// works out the bin with one 32 x $clog2(NUM_BINS + 1) multiply and a restoring divide of one
// quotient bit per cycle; the back end does the count store read-modify-write and a 24-step
// bit-serial square root for an item that hits a bin and skips both for a miss. The two ends
// run apart through a two-entry queue and the result sits in an output register.
// After reset the count store is swept to zero, one entry a cycle, while in_tready stays low;
// cfg_ready is always high and registers should be written only with the block idle.
module histogram_fill_with_error #(
  parameter int NUM_BINS = hfe_pkg::NUM_BINS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [hfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hfe_pkg::SAMPLE_W-1:0]  cfg_data,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [hfe_pkg::IN_DATA_W-1:0] in_tdata,   // sample[31:0], bin_select[39:32]
  input  wire logic                          in_tuser,   // mode
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [hfe_pkg::OUT_DATA_W-1:0]     out_tdata,  // bin_index, bin_total, count_root
  output logic                               out_tuser   // hit
);
  import hfe_pkg::*;

  localparam int IDXW = $clog2(NUM_BINS);
  localparam int QW   = IDXW + $bits(hfe_item_t);

  logic          clear_busy;
  logic          push, full, pop, empty;
  logic [QW-1:0] push_data, pop_data;

  assign cfg_ready = 1'b1;

  hfe_front #(
    .NUM_BINS (NUM_BINS),
    .IDXW     (IDXW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .clear_busy (clear_busy),
    .push       (push),
    .push_data  (push_data),
    .full       (full)
  );

  hfe_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  hfe_back #(
    .NUM_BINS (NUM_BINS),
    .IDXW     (IDXW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear_busy (clear_busy),
    .pop        (pop),
    .pop_data   (pop_data),
    .empty      (empty),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
